>>> rtl/core/interval_stats_monitor_defines.svh
// Assertion macros shared by the interval statistics monitor RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef INTERVAL_STATS_MONITOR_DEFINES_SVH
`define INTERVAL_STATS_MONITOR_DEFINES_SVH

// clocked, reset-qualified property body
`define ISM_PROP(p) @(posedge clk) disable iff (!arst_n) (p)

`define ISM_ASSERT(lbl, p, msg) \
	lbl: assert property (`ISM_PROP(p)) else $error(msg);

`endif

>>> rtl/core/ism_pkg.sv
// Package for the interval statistics monitor: opcodes, widths, constants, control structs.
// No dependencies.
`default_nettype none
package ism_pkg;

	localparam int TICKS_PER_US = 96;
	localparam int AVG_SHIFT = 6;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_STOP   = 2'd1;
	localparam logic [1:0] OP_REPORT = 2'd2;

	localparam int CNT_W = 32;
	localparam int OP_W = 2;
	localparam int US_W = 26;
	localparam int MAX_US_W = 25;
	localparam int OUT_DATA_W = 80;

	localparam logic [CNT_W-1:0] MIN_RESET = 32'h4000_0000;

	localparam int SUM_W = CNT_W + AVG_SHIFT + 1;
	localparam int AVG_HALF = 1 << (AVG_SHIFT - 1);

	localparam int US_HALF = TICKS_PER_US / 2;
	localparam int M_W = CNT_W;
	localparam longint unsigned RECIP = (64'd1 << M_W) / TICKS_PER_US;
	localparam int R_W = $clog2(RECIP + 1);
	localparam int PROD_W = M_W + R_W;
	localparam int Q_W = M_W - $clog2(TICKS_PER_US + 1) + 1;

	typedef struct packed {
		logic s1_load;
		logic s1_fire;
	} stats_ctl_t;

	typedef struct packed {
		logic en_s3;
		logic en_s4;
	} conv_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/ism_stats.sv
// Input register, running min/max/average state and report capture.
// Depends on ism_pkg and interval_stats_monitor_defines.svh.
`default_nettype none
`include "interval_stats_monitor_defines.svh"
module ism_stats (
	input  wire                              clk,
	input  wire                              arst_n,
	input  ism_pkg::stats_ctl_t              ctl,
	input  wire        [ism_pkg::OP_W-1:0]   opcode,
	input  wire        [ism_pkg::CNT_W-1:0]  counter_value,
	output logic                             report_ok,
	output logic signed [ism_pkg::CNT_W-1:0] avg_s2,
	output logic signed [ism_pkg::CNT_W-1:0] min_s2,
	output logic signed [ism_pkg::CNT_W-1:0] max_s2
);

	logic        [ism_pkg::OP_W-1:0]  op_s1;
	logic        [ism_pkg::CNT_W-1:0] cnt_s1;
	logic        [ism_pkg::CNT_W-1:0] start_q;
	logic signed [ism_pkg::CNT_W-1:0] min_q;
	logic signed [ism_pkg::CNT_W-1:0] max_q;
	logic signed [ism_pkg::CNT_W-1:0] avg_q;
	logic signed [ism_pkg::CNT_W-1:0] delta;
	logic signed [ism_pkg::SUM_W-1:0] sum;
	logic signed [ism_pkg::SUM_W-1:0] sum_sh;

	always_ff @(posedge clk) begin
		if (ctl.s1_load) begin
			op_s1  <= opcode;
			cnt_s1 <= counter_value;
		end
	end

	always_comb begin
		delta = signed'(cnt_s1 - start_q);
		sum = (ism_pkg::SUM_W'(avg_q) <<< ism_pkg::AVG_SHIFT) - ism_pkg::SUM_W'(avg_q)
			+ ism_pkg::SUM_W'(delta) + ism_pkg::SUM_W'(ism_pkg::AVG_HALF);
		sum_sh = sum >>> ism_pkg::AVG_SHIFT;
		report_ok = (op_s1 == ism_pkg::OP_REPORT) && (max_q > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			min_q   <= signed'(ism_pkg::MIN_RESET);
			max_q   <= '0;
			avg_q   <= '0;
		end else if (ctl.s1_fire) begin
			case (op_s1)
				ism_pkg::OP_START: begin
					start_q <= cnt_s1;
				end
				ism_pkg::OP_STOP: begin
					if (delta > max_q) max_q <= delta;
					if (delta < min_q) min_q <= delta;
					avg_q <= sum_sh[ism_pkg::CNT_W-1:0];
				end
				ism_pkg::OP_REPORT: begin
					if (max_q > 0) begin
						min_q <= signed'(ism_pkg::MIN_RESET);
						max_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.s1_fire && report_ok) begin
			avg_s2 <= avg_q;
			min_s2 <= min_q;
			max_s2 <= max_q;
		end
	end

	`ISM_ASSERT(a_report_clears, ctl.s1_fire && report_ok |=> max_q == 0 && min_q == signed'(ism_pkg::MIN_RESET), "report did not clear extremes")
	`ISM_ASSERT(a_start_latch, ctl.s1_fire && op_s1 == ism_pkg::OP_START |=> start_q == $past(cnt_s1), "start count not latched")
	`ISM_ASSERT(a_stop_bounds, ctl.s1_fire && op_s1 == ism_pkg::OP_STOP |=> max_q >= $past(delta) && min_q <= $past(delta), "extremes do not bound last duration")

endmodule
`default_nettype wire

>>> rtl/core/ism_us_conv.sv
// Tick to microsecond conversion, (x + half) / ticks truncated toward zero, two stages.
// Reciprocal multiply then one correction step. Depends on ism_pkg.
`default_nettype none
module ism_us_conv (
	input  wire                              clk,
	input  ism_pkg::conv_ctl_t               ctl,
	input  wire signed [ism_pkg::CNT_W-1:0]  ticks,
	output logic       [ism_pkg::US_W-1:0]   us_s4
);

	logic signed [ism_pkg::CNT_W:0]    y;
	logic        [ism_pkg::CNT_W:0]    y_abs;
	logic                              neg_s3;
	logic        [ism_pkg::M_W-1:0]    m_s3;
	logic        [ism_pkg::PROD_W-1:0] prod_s3;
	logic        [ism_pkg::Q_W-1:0]    q_est;
	logic        [ism_pkg::M_W-1:0]    rem;
	logic        [ism_pkg::Q_W-1:0]    q;
	logic        [ism_pkg::CNT_W-1:0]  mag;
	logic        [ism_pkg::CNT_W-1:0]  res;

	always_comb begin
		y = (ism_pkg::CNT_W+1)'(ticks) + (ism_pkg::CNT_W+1)'(ism_pkg::US_HALF);
		y_abs = y[ism_pkg::CNT_W] ? -y : y;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			neg_s3  <= y[ism_pkg::CNT_W];
			m_s3    <= y_abs[ism_pkg::M_W-1:0];
			prod_s3 <= ism_pkg::PROD_W'(y_abs[ism_pkg::M_W-1:0])
				* ism_pkg::PROD_W'(ism_pkg::RECIP);
		end
	end

	// estimate is at most one low
	always_comb begin
		q_est = ism_pkg::Q_W'(prod_s3 >> ism_pkg::M_W);
		rem = m_s3 - ism_pkg::M_W'(q_est) * ism_pkg::M_W'(ism_pkg::TICKS_PER_US);
		q = q_est + ism_pkg::Q_W'(rem >= ism_pkg::M_W'(ism_pkg::TICKS_PER_US));
		mag = ism_pkg::CNT_W'(q);
		res = neg_s3 ? -mag : mag;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4) us_s4 <= res[ism_pkg::US_W-1:0];
	end

endmodule
`default_nettype wire

>>> rtl/core/interval_stats_monitor.sv
// Top level of the interval statistics monitor: stage control and output packing.
// Depends on ism_pkg, ism_stats, ism_us_conv and interval_stats_monitor_defines.svh.
//
// channel  dir  handshake             payload
// s_*      in   s_tvalid / s_tready   tuser: opcode[1:0]; tdata: counter_value[31:0]
// m_*      out  m_tvalid / m_tready   tdata: avg_us[25:0], min_us[51:26], max_us[76:52]
//
// One request per cycle unless the output stalls. Stages: input register, state
// update with report capture, reciprocal multiply, correction into the output register.
// A report with max > 0 goes through the stages to m_tvalid; other opcodes give nothing.
// A stalled output backs up stage by stage; s_tready drops only when all stages hold data.
// arst_n clears valids and the statistics state (min 2^30, max 0, avg 0, start 0).
`default_nettype none
`include "interval_stats_monitor_defines.svh"
module interval_stats_monitor (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [ism_pkg::CNT_W-1:0]           s_tdata,  // counter_value[31:0]
	input  wire  [ism_pkg::OP_W-1:0]            s_tuser,  // opcode[1:0]
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [ism_pkg::OUT_DATA_W-1:0]      m_tdata   // avg_us, min_us, max_us, zero pad
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic report_ok;
	ism_pkg::stats_ctl_t sctl;
	ism_pkg::conv_ctl_t  cctl;
	logic signed [ism_pkg::CNT_W-1:0] avg_s2, min_s2, max_s2;
	logic [ism_pkg::US_W-1:0] avg_us, min_us, max_us;

	always_comb begin
		en4 = !v_s4 || m_tready;
		en3 = !v_s3 || en4;
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
		s_tready = en1;
		sctl.s1_load = s_tvalid && en1;
		sctl.s1_fire = v_s1 && en2;
		cctl.en_s3 = en3;
		cctl.en_s4 = en4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1 && report_ok;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	ism_stats u_stats (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (sctl),
		.opcode        (s_tuser),
		.counter_value (s_tdata),
		.report_ok     (report_ok),
		.avg_s2        (avg_s2),
		.min_s2        (min_s2),
		.max_s2        (max_s2)
	);

	ism_us_conv u_conv_avg (.clk(clk), .ctl(cctl), .ticks(avg_s2), .us_s4(avg_us));
	ism_us_conv u_conv_min (.clk(clk), .ctl(cctl), .ticks(min_s2), .us_s4(min_us));
	ism_us_conv u_conv_max (.clk(clk), .ctl(cctl), .ticks(max_s2), .us_s4(max_us));

	assign m_tvalid = v_s4;
	assign m_tdata = {
		(ism_pkg::OUT_DATA_W - 2*ism_pkg::US_W - ism_pkg::MAX_US_W)'(0),
		max_us[ism_pkg::MAX_US_W-1:0], min_us, avg_us};

	`ISM_ASSERT(a_full_stall, v_s1 && v_s2 && v_s3 && v_s4 && !m_tready |-> !s_tready, "request taken into a full pipeline")
	`ISM_ASSERT(a_report_capture, v_s1 && en2 && report_ok |=> v_s2, "report with data was dropped")
	`ISM_ASSERT(a_accept_lands, s_tvalid && s_tready |=> v_s1, "accepted request not registered")

endmodule
`default_nettype wire
